// ----- rtl/mlbc_pkg.sv -----
// Shared constants, action codes and the per-LED command type of the blink controller.
package mlbc_pkg;

  localparam int NUM_LEDS  = 6;
  localparam int TIME_BITS = 16;
  localparam int ACTION_W  = 3;
  localparam int INDEX_W   = 3;

  localparam logic [TIME_BITS-1:0] DEFAULT_INTERVAL = TIME_BITS'(500);

  localparam logic [ACTION_W-1:0] ACT_TICK   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_ON     = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_OFF    = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_TOGGLE = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_BLINK  = 3'd4;

  typedef struct packed {
    logic tick;
    logic on;
    logic off;
    logic toggle;
    logic blink;
  } cmd_t;

endpackage

// ----- rtl/mlbc_led_channel.sv -----
// State and update logic for one LED: fixed level, toggle and timed blink.
module mlbc_led_channel (
  input  logic                          clk,
  input  logic                          rst,
  input  mlbc_pkg::cmd_t                cmd,
  input  logic [mlbc_pkg::TIME_BITS-1:0] blink_interval,
  input  logic [mlbc_pkg::TIME_BITS-1:0] blink_timeout,
  output logic                          level,
  output logic                          blinking
);

  logic                           saved_level;
  logic [mlbc_pkg::TIME_BITS-1:0] interval_store;
  logic [mlbc_pkg::TIME_BITS-1:0] timeout_store;
  logic [mlbc_pkg::TIME_BITS:0]   elapsed_time;
  logic [mlbc_pkg::TIME_BITS-1:0] phase_count;

  logic                           level_next;
  logic                           blinking_next;
  logic                           saved_level_next;
  logic [mlbc_pkg::TIME_BITS-1:0] interval_store_next;
  logic [mlbc_pkg::TIME_BITS-1:0] timeout_store_next;
  logic [mlbc_pkg::TIME_BITS:0]   elapsed_time_next;
  logic [mlbc_pkg::TIME_BITS-1:0] phase_count_next;

  logic [mlbc_pkg::TIME_BITS-1:0] phase_inc;
  logic [mlbc_pkg::TIME_BITS:0]   elapsed_sum;
  logic [mlbc_pkg::TIME_BITS-1:0] interval_eff;
  logic                           same_blink;

  assign phase_inc    = phase_count + mlbc_pkg::TIME_BITS'(1);
  assign elapsed_sum  = elapsed_time + {1'b0, interval_store};
  assign interval_eff = (blink_interval == '0) ? mlbc_pkg::TIME_BITS'(1) : blink_interval;
  assign same_blink   = blinking && (interval_store == interval_eff)
                        && (timeout_store == blink_timeout);

  always_comb begin
    level_next          = level;
    blinking_next       = blinking;
    saved_level_next    = saved_level;
    interval_store_next = interval_store;
    timeout_store_next  = timeout_store;
    elapsed_time_next   = elapsed_time;
    phase_count_next    = phase_count;
    if (cmd.tick && blinking) begin
      if (phase_inc < interval_store) begin
        phase_count_next = phase_inc;
      end else begin
        phase_count_next = '0;
        level_next       = !level;
        if (timeout_store != '0) begin
          elapsed_time_next = elapsed_sum;
          if (elapsed_sum >= {1'b0, timeout_store}) begin
            blinking_next = 1'b0;
            level_next    = saved_level;
          end
        end
      end
    end else if (cmd.on) begin
      blinking_next = 1'b0;
      level_next    = 1'b1;
    end else if (cmd.off) begin
      blinking_next = 1'b0;
      level_next    = 1'b0;
    end else if (cmd.toggle) begin
      blinking_next = 1'b0;
      level_next    = !(blinking || level);
    end else if (cmd.blink && !same_blink) begin
      blinking_next       = 1'b1;
      interval_store_next = interval_eff;
      timeout_store_next  = blink_timeout;
      elapsed_time_next   = '0;
      phase_count_next    = '0;
      saved_level_next    = level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level          <= 1'b0;
      blinking       <= 1'b0;
      saved_level    <= 1'b0;
      interval_store <= mlbc_pkg::DEFAULT_INTERVAL;
      timeout_store  <= '0;
      elapsed_time   <= '0;
      phase_count    <= '0;
    end else begin
      level          <= level_next;
      blinking       <= blinking_next;
      saved_level    <= saved_level_next;
      interval_store <= interval_store_next;
      timeout_store  <= timeout_store_next;
      elapsed_time   <= elapsed_time_next;
      phase_count    <= phase_count_next;
    end
  end

endmodule

// ----- rtl/multi_led_blink_controller_unit.sv -----
// Top level: input register, per-LED channels and the result register.
// The result is offered once the accepted item has moved from the input register into the LED channel registers.
// Throughput: one transaction per cycle while no result is held back by a low out_ready.
// The input register accepts a new item while a result still waits downstream, if it holds no item itself.
// Synchronous reset: all LEDs off, no blinking, intervals 500, timeouts and counts zero.
module multi_led_blink_controller_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mlbc_pkg::ACTION_W-1:0]       action,
  input  logic [mlbc_pkg::INDEX_W-1:0]        led_index,
  input  logic [mlbc_pkg::TIME_BITS-1:0]      blink_interval,
  input  logic [mlbc_pkg::TIME_BITS-1:0]      blink_timeout,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mlbc_pkg::NUM_LEDS-1:0]       led_levels,
  output logic [mlbc_pkg::NUM_LEDS-1:0]       blinking_mask
);

  logic                           in_valid_q;
  logic [mlbc_pkg::ACTION_W-1:0]  action_q;
  logic [mlbc_pkg::INDEX_W-1:0]   led_index_q;
  logic [mlbc_pkg::TIME_BITS-1:0] blink_interval_q;
  logic [mlbc_pkg::TIME_BITS-1:0] blink_timeout_q;
  logic                           advance;

  assign advance  = in_valid_q && (!out_valid || out_ready);
  assign in_ready = !in_valid_q || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      action_q         <= action;
      led_index_q      <= led_index;
      blink_interval_q <= blink_interval;
      blink_timeout_q  <= blink_timeout;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  for (genvar k = 0; k < mlbc_pkg::NUM_LEDS; k++) begin : g_led
    mlbc_pkg::cmd_t cmd;
    logic           sel;

    assign sel        = advance && (led_index_q == mlbc_pkg::INDEX_W'(k));
    assign cmd.tick   = advance && (action_q == mlbc_pkg::ACT_TICK);
    assign cmd.on     = sel && (action_q == mlbc_pkg::ACT_ON);
    assign cmd.off    = sel && (action_q == mlbc_pkg::ACT_OFF);
    assign cmd.toggle = sel && (action_q == mlbc_pkg::ACT_TOGGLE);
    assign cmd.blink  = sel && (action_q == mlbc_pkg::ACT_BLINK);

    mlbc_led_channel u_channel (
      .clk            (clk),
      .rst            (rst),
      .cmd            (cmd),
      .blink_interval (blink_interval_q),
      .blink_timeout  (blink_timeout_q),
      .level          (led_levels[k]),
      .blinking       (blinking_mask[k])
    );
  end

`ifndef SYNTH
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(led_levels) && $stable(blinking_mask)))
    else $error("LED state changed without a transaction");

  a_advance_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed transaction produced no result");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (in_valid_q && out_valid && !out_ready))
    else $error("input stalled without a blocked result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !advance)
    else $error("pending result overwritten");
`endif

endmodule
